// ===== design/ott_pkg.sv =====
package ott_pkg;

  // table geometry
  localparam int Entries = 8;
  localparam int IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int CntW = 4;
  localparam int IdW = 16;
  localparam int TimeW = 32;
  localparam int TokW = 64;
  localparam int TokLenW = 4;
  localparam int TokBytes = TokW / 8;

  localparam logic [TimeW-1:0] DefaultInterval = 32'd2000;
  localparam logic [CntW-1:0] EntriesCnt = CntW'(Entries);
  localparam logic [TokLenW-1:0] MaxTokLen = TokLenW'(TokBytes);

  // operation codes
  typedef enum logic [1:0] {
    KindCheck    = 2'd0,
    KindResetMid = 2'd1,
    KindSetToken = 2'd2,
    KindSetMid   = 2'd3
  } kind_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    RegIdsLow  = 2'd0,
    RegIdsHigh = 2'd1,
    RegCount   = 2'd2,
    RegNone    = 2'd3
  } reg_idx_e;

  typedef enum logic {
    StIdle = 1'b0,
    StScan = 1'b1
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
    logic miss;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic last;
  } stat_t;

endpackage

// ===== design/ott_ctrl.sv =====
module ott_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  ott_pkg::stat_t stat_i,
  output ott_pkg::cmd_t  cmd_o,
  output logic           busy_o
);

  ott_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ott_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      ott_pkg::StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = ott_pkg::StScan;
        end
      end
      ott_pkg::StScan: begin
        if (stat_i.hit) begin
          cmd_o.commit = 1'b1;
          state_d = ott_pkg::StIdle;
        end else if (stat_i.last) begin
          cmd_o.miss = 1'b1;
          state_d = ott_pkg::StIdle;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = ott_pkg::StIdle;
      end
    endcase
  end

  assign busy_o = (state_q != ott_pkg::StIdle);

endmodule

// ===== design/ott_dp.sv =====
module ott_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ott_pkg::cmd_t                     cmd_i,
  output ott_pkg::stat_t                    stat_o,
  input  logic                              cfg_valid_i,
  input  logic [1:0]                        cfg_index_i,
  input  logic [63:0]                       cfg_data_i,
  input  logic [1:0]                        kind_i,
  input  logic signed [ott_pkg::IdW-1:0]    resource_id_i,
  input  logic [ott_pkg::TimeW-1:0]         arg_i,
  input  logic [ott_pkg::TokW-1:0]          token_bytes_i,
  input  logic [ott_pkg::TokLenW-1:0]       token_length_i,
  output logic                              done_o,
  output logic                              status_o,
  output logic signed [ott_pkg::IdW-1:0]    due_resource_id_o,
  output logic [ott_pkg::TokW-1:0]          due_token_o,
  output logic [ott_pkg::TokLenW-1:0]       due_token_length_o
);

  // configuration registers
  logic [63:0] ids_low_q, ids_high_q;
  logic [ott_pkg::CntW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ids_low_q <= '0;
      ids_high_q <= '0;
      count_q <= '0;
    end else if (cfg_valid_i) begin
      case (ott_pkg::reg_idx_e'(cfg_index_i))
        ott_pkg::RegIdsLow:  ids_low_q <= cfg_data_i;
        ott_pkg::RegIdsHigh: ids_high_q <= cfg_data_i;
        ott_pkg::RegCount:   count_q <= cfg_data_i[ott_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  // latched request
  ott_pkg::kind_e kind_q;
  logic [ott_pkg::IdW-1:0] rid_q;
  logic [ott_pkg::TimeW-1:0] arg_q;
  logic [ott_pkg::TokW-1:0] tok_q;
  logic [ott_pkg::TokLenW-1:0] tlen_q;
  logic [ott_pkg::IdxW-1:0] idx_q;

  // saturate token length and zero the bytes past it
  logic [ott_pkg::TokLenW-1:0] tlen_sat;
  logic [ott_pkg::TokW-1:0] tok_masked;

  always_comb begin
    tlen_sat = (token_length_i > ott_pkg::MaxTokLen) ? ott_pkg::MaxTokLen : token_length_i;
    for (int b = 0; b < ott_pkg::TokBytes; b++) begin
      tok_masked[b*8 +: 8] = (ott_pkg::TokLenW'(b) < tlen_sat) ? token_bytes_i[b*8 +: 8]
                                                               : 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= ott_pkg::kind_e'(kind_i);
      rid_q <= resource_id_i;
      arg_q <= arg_i;
      tok_q <= tok_masked;
      tlen_q <= tlen_sat;
    end
  end

  // scan index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // entry table
  logic [ott_pkg::TokW-1:0]    tok_mem_q   [ott_pkg::Entries];
  logic [ott_pkg::TokLenW-1:0] tlen_mem_q  [ott_pkg::Entries];
  logic [ott_pkg::TimeW-1:0]   start_mem_q [ott_pkg::Entries];
  logic [ott_pkg::TimeW-1:0]   ivl_mem_q   [ott_pkg::Entries];
  logic [ott_pkg::TimeW-1:0]   mid_mem_q   [ott_pkg::Entries];

  // current entry
  logic [127:0] ids_all;
  logic [ott_pkg::IdW-1:0] cur_id;
  logic [ott_pkg::TimeW-1:0] elapsed;
  logic [ott_pkg::CntW-1:0] active_n;
  logic in_range, match;

  always_comb begin
    ids_all = {ids_high_q, ids_low_q};
    cur_id = ids_all[32'(idx_q)*ott_pkg::IdW +: ott_pkg::IdW];
    elapsed = arg_q - start_mem_q[idx_q];
    active_n = (count_q > ott_pkg::EntriesCnt) ? ott_pkg::EntriesCnt : count_q;
    in_range = (ott_pkg::CntW'(idx_q) < active_n);
    case (kind_q)
      ott_pkg::KindCheck:    match = (tlen_mem_q[idx_q] != '0) &&
                                     (elapsed >= ivl_mem_q[idx_q]);
      ott_pkg::KindResetMid: match = (mid_mem_q[idx_q] == arg_q);
      ott_pkg::KindSetToken: match = (cur_id == rid_q);
      ott_pkg::KindSetMid:   match = (cur_id == rid_q);
      default:               match = 1'b0;
    endcase
    stat_o.hit = in_range && match;
    stat_o.last = !in_range || ((ott_pkg::CntW'(idx_q) + 1'b1) >= active_n);
  end

  // entry update on a hit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < ott_pkg::Entries; e++) begin
        tok_mem_q[e] <= '0;
        tlen_mem_q[e] <= '0;
        start_mem_q[e] <= '0;
        ivl_mem_q[e] <= '0;
        mid_mem_q[e] <= '0;
      end
    end else if (cmd_i.commit) begin
      case (kind_q)
        ott_pkg::KindCheck: begin
          start_mem_q[idx_q] <= arg_q;
        end
        ott_pkg::KindResetMid: begin
          mid_mem_q[idx_q] <= '0;
          tlen_mem_q[idx_q] <= '0;
        end
        ott_pkg::KindSetToken: begin
          tok_mem_q[idx_q] <= tok_q;
          tlen_mem_q[idx_q] <= tlen_q;
          start_mem_q[idx_q] <= arg_q;
          if (ivl_mem_q[idx_q] == '0) begin
            ivl_mem_q[idx_q] <= ott_pkg::DefaultInterval;
          end
        end
        ott_pkg::KindSetMid: begin
          mid_mem_q[idx_q] <= arg_q;
        end
        default: ;
      endcase
    end
  end

  // result strobe
  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.commit || cmd_i.miss;
    end
  end

  // result registers
  logic status_q;
  logic [ott_pkg::IdW-1:0] due_id_q;
  logic [ott_pkg::TokW-1:0] due_tok_q;
  logic [ott_pkg::TokLenW-1:0] due_tlen_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= 1'b0;
      if (kind_q == ott_pkg::KindCheck) begin
        due_id_q <= cur_id;
        due_tok_q <= tok_mem_q[idx_q];
        due_tlen_q <= tlen_mem_q[idx_q];
      end else begin
        due_id_q <= '0;
        due_tok_q <= '0;
        due_tlen_q <= '0;
      end
    end else if (cmd_i.miss) begin
      status_q <= 1'b1;
      due_id_q <= '0;
      due_tok_q <= '0;
      due_tlen_q <= '0;
    end
  end

  assign done_o = done_q;
  assign status_o = status_q;
  assign due_resource_id_o = due_id_q;
  assign due_token_o = due_tok_q;
  assign due_token_length_o = due_tlen_q;

endmodule

// ===== design/observe_timer_table.sv =====
// the result strobe follows start through the load, the scan of the active entries and the
//   result register; the scan state is entered even when no entry is active
// one entry is examined per cycle, and a new request is taken only while the table is idle;
//   busy drops in the cycle the result is shown, so the next start can follow at once
// reset clears the configuration, the whole entry table and the controller at once
// results are shown for one cycle on done_o; the receiver cannot stall
module observe_timer_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [63:0]                       cfg_data_i,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        kind_i,
  input  logic signed [ott_pkg::IdW-1:0]    resource_id_i,
  input  logic [ott_pkg::TimeW-1:0]         arg_i,
  input  logic [ott_pkg::TokW-1:0]          token_bytes_i,
  input  logic [ott_pkg::TokLenW-1:0]       token_length_i,
  output logic                              done_o,
  output logic                              status_o,
  output logic signed [ott_pkg::IdW-1:0]    due_resource_id_o,
  output logic [ott_pkg::TokW-1:0]          due_token_o,
  output logic [ott_pkg::TokLenW-1:0]       due_token_length_o
);

  ott_pkg::cmd_t cmd;
  ott_pkg::stat_t stat;
  logic busy;

  // configuration transfers are always taken
  assign cfg_ready_o = 1'b1;
  assign busy_o = busy;

  ott_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  ott_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .kind_i             (kind_i),
    .resource_id_i      (resource_id_i),
    .arg_i              (arg_i),
    .token_bytes_i      (token_bytes_i),
    .token_length_i     (token_length_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .due_resource_id_o  (due_resource_id_o),
    .due_token_o        (due_token_o),
    .due_token_length_o (due_token_length_o)
  );

endmodule
